>>> rtl/scics_pkg.sv
// ----------------------------------------------------------------------------
// scics_pkg
// Shared widths, register indexes and helpers for the sphere-in-cell test.
// ----------------------------------------------------------------------------
package scics_pkg;

  localparam int CW  = 32;        // coordinate width, signed fixed point
  localparam int UW  = CW - 1;    // unsigned length width
  localparam int SQW = 2 * CW;    // width of an exact square
  localparam int IXW = 3;         // register index width

  typedef enum logic [IXW-1:0] {
    REG_CELL_RADIUS      = 3'd0,
    REG_CELL_HALF_LENGTH = 3'd1,
    REG_TUBE_HALF_LENGTH = 3'd2,
    REG_BORE_RADIUS      = 3'd3,
    REG_ARC_RADIUS       = 3'd4
  } cfg_reg_e;

  // Fields that ride alongside the root pipeline
  typedef struct packed {
    logic [SQW-1:0] rad2;     // x*x + y*y
    logic [CW-1:0]  tra;      // bore radius + arc radius
    logic           decided;  // answer known before the root
    logic           early;    // that answer
  } side_t;

  // Magnitude of a signed difference that is known to fit CW bits
  function automatic logic [CW-1:0] mag_f(logic signed [CW+1:0] v);
    logic signed [CW+1:0] t;
    t = v[CW+1] ? -v : v;
    return t[CW-1:0];
  endfunction

endpackage

>>> rtl/scics_if.sv
// ----------------------------------------------------------------------------
// scics_in_if / scics_out_if
// Valid/ready channels for sphere items and test results.
// ----------------------------------------------------------------------------
interface scics_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [scics_pkg::CW-1:0] centre_x;
  logic signed [scics_pkg::CW-1:0] centre_y;
  logic signed [scics_pkg::CW-1:0] centre_z;
  logic [scics_pkg::UW-1:0]        sphere_radius;

  modport source (output valid, centre_x, centre_y, centre_z, sphere_radius, input ready);
  modport sink (input valid, centre_x, centre_y, centre_z, sphere_radius, output ready);
endinterface

interface scics_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

>>> rtl/sphere_in_channel_cell_test.sv
// ----------------------------------------------------------------------------
// sphere_in_channel_cell_test
// Tests whether a sphere lies wholly inside a two-compartment channel cell.
// ----------------------------------------------------------------------------
// One item enters per cycle unless the result is stalled; each item gives
// one result via the 32-stage square root pipeline (one root bit per stage)
// and the abs/sum, square and compare stages around it. The whole pipeline
// holds as one while the result is stalled. The user must write registers
// through the plain write port while the block is idle; nothing enforces it.
module sphere_in_channel_cell_test (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [scics_pkg::IXW-1:0] cfg_idx_i,
  input  logic [scics_pkg::UW-1:0]  cfg_data_i,
  scics_in_if.sink                  item_i,
  scics_out_if.source               res_o
);
  import scics_pkg::*;

  logic [UW-1:0] cr_q, ch_q, th_q, tr_q, arc_q;
  logic          adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q  <= '0;
      ch_q  <= '0;
      th_q  <= '0;
      tr_q  <= '0;
      arc_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CELL_RADIUS:      cr_q  <= cfg_data_i;
        REG_CELL_HALF_LENGTH: ch_q  <= cfg_data_i;
        REG_TUBE_HALF_LENGTH: th_q  <= cfg_data_i;
        REG_BORE_RADIUS:      tr_q  <= cfg_data_i;
        REG_ARC_RADIUS:       arc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance every stage unless the result register is stalled
  assign adv          = !res_o.valid || res_o.ready;
  assign item_i.ready = adv;

  // stage A: captured item
  logic                 a_vld_q;
  logic signed [CW-1:0] a_x_q, a_y_q, a_z_q;
  logic [UW-1:0]        a_r_q;

  // stage B: magnitudes and sums
  logic                 b_vld_q;
  logic [CW-1:0]        b_az_q, b_mx_q, b_my_q, b_thr_q, b_mcrd_q, b_mtrd_q, b_tra_q, b_ar_q;
  logic signed [CW+1:0] b_zlim_q, b_vest_q;

  // stage C: squares and z flags
  logic                 c_vld_q;
  logic [SQW-1:0]       c_x2_q, c_y2_q, c_sqcr_q, c_sqtrd_q, c_sqtra_q, c_a2_q;
  logic [CW-1:0]        c_bd_q, c_tra_q;
  logic                 c_comp_q, c_zbad_q, c_vestf_q;

  // stage D: radial sum and vestibule square
  logic                 d_vld_q;
  logic [SQW-1:0]       d_rad2_q, d_b2_q, d_sqcr_q, d_sqtrd_q, d_sqtra_q, d_a2_q;
  logic [CW-1:0]        d_tra_q;
  logic                 d_comp_q, d_zbad_q, d_vestf_q;

  // stage E: early decisions and root argument
  logic                 e_vld_q;
  logic [SQW-1:0]       e_d_q;
  side_t                e_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= item_i.valid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  logic signed [CW+1:0] az_ext, vest_ext;
  assign az_ext   = $signed({2'b00, b_az_q});
  assign vest_ext = b_vest_q;

  side_t e_side_d;
  logic  e_neg;
  always_comb begin
    e_neg            = (d_a2_q < d_b2_q);
    e_side_d.rad2    = d_rad2_q;
    e_side_d.tra     = d_tra_q;
    e_side_d.decided = 1'b1;
    e_side_d.early   = 1'b0;
    if (d_comp_q) begin
      e_side_d.early = !((d_rad2_q > d_sqcr_q) || d_zbad_q);
    end else if (d_rad2_q <= d_sqtrd_q) begin
      e_side_d.early = 1'b1;
    end else if (d_vestf_q || (d_rad2_q > d_sqtra_q) || e_neg) begin
      e_side_d.early = 1'b0;
    end else begin
      e_side_d.decided = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_x_q <= item_i.centre_x;
      a_y_q <= item_i.centre_y;
      a_z_q <= item_i.centre_z;
      a_r_q <= item_i.sphere_radius;

      b_az_q   <= mag_f((CW+2)'(a_z_q));
      b_mx_q   <= mag_f((CW+2)'(a_x_q));
      b_my_q   <= mag_f((CW+2)'(a_y_q));
      b_thr_q  <= CW'({1'b0, th_q} + {1'b0, a_r_q});
      b_zlim_q <= $signed({3'b000, ch_q}) + $signed({3'b000, th_q})
                  - $signed({3'b000, a_r_q});
      b_mcrd_q <= mag_f($signed({3'b000, cr_q}) - $signed({3'b000, a_r_q}));
      b_mtrd_q <= mag_f($signed({3'b000, tr_q}) - $signed({3'b000, a_r_q}));
      b_tra_q  <= CW'({1'b0, tr_q} + {1'b0, arc_q});
      b_ar_q   <= CW'({1'b0, arc_q} + {1'b0, a_r_q});
      b_vest_q <= $signed({3'b000, th_q}) - $signed({3'b000, arc_q});

      c_x2_q    <= b_mx_q * b_mx_q;
      c_y2_q    <= b_my_q * b_my_q;
      c_sqcr_q  <= b_mcrd_q * b_mcrd_q;
      c_sqtrd_q <= b_mtrd_q * b_mtrd_q;
      c_sqtra_q <= b_tra_q * b_tra_q;
      c_a2_q    <= b_ar_q * b_ar_q;
      c_bd_q    <= mag_f(az_ext - vest_ext);
      c_tra_q   <= b_tra_q;
      c_comp_q  <= (b_az_q >= b_thr_q);
      c_zbad_q  <= (az_ext > b_zlim_q);
      c_vestf_q <= (az_ext <= vest_ext);

      d_rad2_q  <= c_x2_q + c_y2_q;
      d_b2_q    <= c_bd_q * c_bd_q;
      d_sqcr_q  <= c_sqcr_q;
      d_sqtrd_q <= c_sqtrd_q;
      d_sqtra_q <= c_sqtra_q;
      d_a2_q    <= c_a2_q;
      d_tra_q   <= c_tra_q;
      d_comp_q  <= c_comp_q;
      d_zbad_q  <= c_zbad_q;
      d_vestf_q <= c_vestf_q;

      e_d_q    <= e_neg ? '0 : (d_a2_q - d_b2_q);
      e_side_q <= e_side_d;
    end
  end

  logic          s_vld;
  logic [CW-1:0] s_root;
  side_t         s_side;

  scics_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (e_vld_q),
    .rad_i   (e_d_q),
    .side_i  (e_side_q),
    .valid_o (s_vld),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  // stage F: arc offset magnitude, stage G: its square, then the result
  logic           f_vld_q, g_vld_q, out_vld_q, out_res_q;
  logic [CW-1:0]  f_mag_q;
  side_t          f_side_q, g_side_q;
  logic [SQW-1:0] g_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q   <= 1'b0;
      g_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      f_vld_q   <= s_vld;
      g_vld_q   <= f_vld_q;
      out_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_mag_q   <= mag_f($signed({2'b00, s_side.tra}) - $signed({2'b00, s_root}));
      f_side_q  <= s_side;
      g_sq_q    <= f_mag_q * f_mag_q;
      g_side_q  <= f_side_q;
      out_res_q <= g_side_q.decided ? g_side_q.early : (g_side_q.rad2 <= g_sq_q);
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.inside_res = out_res_q;

  // a stalled result must hold the whole pipeline, input included
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !item_i.ready)
    else $error("input taken while result stalled");

  // a cycle without a transfer leaves a bubble in the first stage
  a_bubble_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !item_i.valid) |=> !a_vld_q)
    else $error("stage A valid without a transfer");

  // a stalled pipeline keeps the root stage output
  a_root_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && s_vld) |=> (s_vld && $stable(s_root)))
    else $error("root pipeline moved during stall");

endmodule

>>> rtl/scics_isqrt.sv
// ----------------------------------------------------------------------------
// scics_isqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module scics_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [scics_pkg::SQW-1:0] rad_i,
  input  scics_pkg::side_t          side_i,
  output logic                      valid_o,
  output logic [scics_pkg::CW-1:0]  root_o,
  output scics_pkg::side_t          side_o
);
  import scics_pkg::*;

  localparam int NS = CW;

  logic [NS-1:0]  vld_q;
  logic [CW+1:0]  rem_q  [NS];
  logic [CW-1:0]  root_q [NS];
  logic [SQW-1:0] rad_q  [NS];
  side_t          side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int BI = NS - 1 - k;
    logic [CW+1:0]  rem_in;
    logic [CW-1:0]  root_in;
    logic [SQW-1:0] rad_in;
    side_t          side_in;
    logic           vld_in;
    logic [CW+1:0]  rsh;
    logic [CW+1:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rsh   = {rem_in[CW-1:0], rad_in[2*BI+1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (rsh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rsh - trial) : rsh;
        root_q[k] <= {root_in[CW-2:0], ge};
        rad_q[k]  <= rad_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

>>> bench/scics_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scics_checker
// Watches the register port and both channels of the sphere-in-cell block,
// predicts the inside flag of every accepted sphere and compares it with the
// results in order.
// ----------------------------------------------------------------------------
module scics_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [scics_pkg::IXW-1:0] cfg_idx_i,
  input  logic [scics_pkg::UW-1:0]  cfg_data_i,
  scics_in_if                       item_if,
  scics_out_if                      res_if,
  output int                        errors_o,
  output int                        pending_o
);
  import scics_pkg::*;

  longint cell_r, cell_hl, tube_hl, tube_r, arc_r;
  bit     inside_q[$];

  function automatic bit [127:0] square_of(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    return {64'd0, m} * {64'd0, m};
  endfunction

  function automatic longint unsigned root_floor(bit [127:0] d);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (({64'd0, c} * {64'd0, c}) <= d) r = c;
    end
    return r;
  endfunction

  function automatic bit sphere_inside(longint x, longint y, longint z, longint r);
    longint     az;
    longint     vest;
    bit [127:0] rad2;
    bit [127:0] a2;
    bit [127:0] b2;
    longint unsigned ddr;
    az   = (z < 0) ? -z : z;
    rad2 = square_of(x) + square_of(y);
    vest = tube_hl - arc_r;
    // compartment beyond the membrane
    if (az >= tube_hl + r) begin
      if (rad2 > square_of(cell_r - r)) return 1'b0;
      if (az > cell_hl + tube_hl - r) return 1'b0;
      return 1'b1;
    end
    if (rad2 <= square_of(tube_r - r)) return 1'b1;
    if (az <= vest) return 1'b0;
    if (rad2 > square_of(tube_r + arc_r)) return 1'b0;
    a2 = square_of(arc_r + r);
    b2 = square_of(az - vest);
    if (a2 < b2) return 1'b0;
    ddr = root_floor(a2 - b2);
    return rad2 <= square_of(tube_r + arc_r - longint'(ddr));
  endfunction

  task automatic report_mismatch(string what);
    $display("tb: mismatch at %0t: %s", $time, what);
    errors_o++;
  endtask

  assign pending_o = inside_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_r  <= 0;
      cell_hl <= 0;
      tube_hl <= 0;
      tube_r  <= 0;
      arc_r   <= 0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CELL_RADIUS:      cell_r  <= longint'(cfg_data_i);
        REG_CELL_HALF_LENGTH: cell_hl <= longint'(cfg_data_i);
        REG_TUBE_HALF_LENGTH: tube_hl <= longint'(cfg_data_i);
        REG_BORE_RADIUS:      tube_r  <= longint'(cfg_data_i);
        REG_ARC_RADIUS:       arc_r   <= longint'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    bit want;
    if (rst_ni) begin
      if (item_if.valid && item_if.ready)
        inside_q.insert(inside_q.size(),
                        sphere_inside(longint'(item_if.centre_x),
                                      longint'(item_if.centre_y),
                                      longint'(item_if.centre_z),
                                      longint'(item_if.sphere_radius)));
      if (res_if.valid && res_if.ready) begin
        if (inside_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = inside_q.pop_front();
          if (res_if.inside_res !== want)
            report_mismatch($sformatf("inside_res %b, expected %b", res_if.inside_res, want));
        end
      end
    end
  end

endmodule

>>> bench/sphere_in_channel_cell_test_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_in_channel_cell_test_test
// Stimulus and verdict for the sphere-in-cell block: register settings from
// zero to full scale, directed spheres for each region of the cell, then
// bursts of random spheres against a stalling result receiver.
// ----------------------------------------------------------------------------
module sphere_in_channel_cell_test_test;
  import scics_pkg::*;

  localparam longint ONE   = 64'd1 << 16;
  localparam int     LIMIT = 400000;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we;
  logic [IXW-1:0] cfg_idx;
  logic [UW-1:0] cfg_data;
  int            errors;
  int            pending;
  int            cycles;
  int            burst_left;
  int            hold_cnt;
  bit            hold_go;
  bit            hold_done;
  int            stall_mode;
  longint        geo_scale;

  scics_in_if  item_if ();
  scics_out_if res_if ();

  sphere_in_channel_cell_test u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .item_i    (item_if),
    .res_o     (res_if)
  );

  scics_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .item_if   (item_if),
    .res_if    (res_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: random stall modes; one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    hold_cnt     = 0;
    hold_done    = 1'b0;
    stall_mode   = 0;
    forever begin
      @(posedge clk_i);
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_go && !hold_done && hold_cnt == 0) begin
        hold_cnt  = 300;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= $urandom_range(0, 1);
          2:       res_if.ready <= ($urandom_range(0, 7) != 0);
          default: res_if.ready <= ((cycles % 8) < 3);
        endcase
      end
    end
  end

  task automatic send_sphere(longint x, longint y, longint z, longint r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    item_if.valid         <= 1'b1;
    item_if.centre_x      <= x[CW-1:0];
    item_if.centre_y      <= y[CW-1:0];
    item_if.centre_z      <= z[CW-1:0];
    item_if.sphere_radius <= r[UW-1:0];
    do @(posedge clk_i); while (!item_if.ready);
    burst_left--;
  endtask

  task automatic drain;
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, longint val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[UW-1:0];
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_geometry(longint cr, longint chl, longint thl, longint tr, longint ar);
    write_reg(REG_CELL_RADIUS, cr);
    write_reg(REG_CELL_HALF_LENGTH, chl);
    write_reg(REG_TUBE_HALF_LENGTH, thl);
    write_reg(REG_BORE_RADIUS, tr);
    write_reg(REG_ARC_RADIUS, ar);
  endtask

  function automatic longint rnd_full();
    return longint'($signed($urandom()));
  endfunction

  function automatic longint rnd_span(longint lim);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Mostly spheres placed around the cell geometry, some full-range noise; all noise while geo_scale is zero
  task automatic random_spheres(int n);
    longint x, y, z, r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0 || geo_scale == 0) begin
        x = rnd_full();
        y = rnd_full();
        z = rnd_full();
        r = longint'($urandom() >> 1);
      end else begin
        x = rnd_span(geo_scale);
        y = rnd_span(geo_scale);
        z = rnd_span(2 * geo_scale);
        r = longint'($urandom_range(0, 32'(geo_scale / 3)));
        if ($urandom_range(0, 2) == 0) x = x / 4;
        if ($urandom_range(0, 2) == 0) y = y / 4;
      end
      send_sphere(x, y, z, r);
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = REG_CELL_RADIUS;
    cfg_data              = '0;
    item_if.valid         = 1'b0;
    item_if.centre_x      = '0;
    item_if.centre_y      = '0;
    item_if.centre_z      = '0;
    item_if.sphere_radius = '0;
    hold_go               = 1'b0;
    burst_left            = 0;
    geo_scale             = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at reset
    random_spheres(20);
    drain();

    set_geometry(20 * ONE, 30 * ONE, 10 * ONE, 5 * ONE, 3 * ONE);
    // unused register indexes must be ignored
    for (int k = 1; k <= 3; k++)
      write_reg(cfg_reg_e'(REG_ARC_RADIUS + k), longint'($urandom() >> 1));
    geo_scale = 25 * ONE;
    send_sphere(0, 0, 0, 0);
    send_sphere(0, 0, 0, 64'h7fff_ffff);
    send_sphere(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, 0);
    send_sphere(64'sh7fff_ffff, 64'sh7fff_ffff, 64'sh7fff_ffff, 64'h7fff_ffff);
    send_sphere(64'sh7fff_ffff, -64'sh8000_0000, 0, 0);
    send_sphere(0, 0, 20 * ONE, 2 * ONE);
    send_sphere(0, 0, -20 * ONE, 2 * ONE);
    send_sphere(19 * ONE, 0, 20 * ONE, 2 * ONE);
    send_sphere(0, 0, 39 * ONE, 2 * ONE);
    send_sphere(0, 0, 60 * ONE, 50 * ONE);
    send_sphere(0, 0, 12 * ONE, 2 * ONE);
    send_sphere(2 * ONE, ONE, 0, 2 * ONE);
    send_sphere(6 * ONE, 0, 3 * ONE, ONE);
    send_sphere(10 * ONE, 0, 8 * ONE, ONE);
    send_sphere(6 * ONE, 0, 9 * ONE, ONE);
    send_sphere(7 * ONE, 0, 19 * ONE / 2, ONE);
    send_sphere(6 * ONE, ONE, -9 * ONE, ONE);
    send_sphere(5 * ONE, 5 * ONE, 9 * ONE, ONE / 2);
    random_spheres(80);
    hold_go = 1'b1;
    random_spheres(150);
    // let the pipeline empty before going on
    drain();
    random_spheres(40);
    drain();

    set_geometry(40 * ONE, 10 * ONE, 4 * ONE, 12 * ONE, 8 * ONE);
    geo_scale = 45 * ONE;
    random_spheres(130);
    drain();

    set_geometry(15 * ONE, 20 * ONE, 12 * ONE, 2 * ONE, ONE / 3);
    geo_scale = 20 * ONE;
    random_spheres(70);
    drain();

    set_geometry(0, 0, 0, 0, 0);
    geo_scale = 0;
    random_spheres(30);
    drain();

    set_geometry(64'h7fff_ffff, 64'h7fff_ffff, 64'h7fff_ffff, 64'h7fff_ffff, 64'h7fff_ffff);
    random_spheres(50);
    drain();

    set_geometry(longint'($urandom() >> 1), longint'($urandom() >> 1),
                 longint'($urandom() >> 1), longint'($urandom() >> 1),
                 longint'($urandom() >> 1));
    random_spheres(60);
    drain();

    repeat (60) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
